// ===== design/mcm_pkg.sv =====
// ----------------------------------------------------------------------------
// mcm_pkg: shared definitions for the modulator curve map
// register map, curve and output mode codes, per-port curve settings
// ----------------------------------------------------------------------------
package mcm_pkg;

   // default widths
   localparam int SOURCE_BITS_DEF = 14;
   localparam int FRAC_BITS_DEF   = 15;

   // configuration register indexes (byte address 4*index)
   typedef enum logic [2:0] {
      REG_PORT0_LOW   = 3'd0,
      REG_PORT0_HIGH  = 3'd1,
      REG_PORT1_LOW   = 3'd2,
      REG_PORT1_HIGH  = 3'd3,
      REG_PORT0_CURVE = 3'd4,
      REG_PORT1_CURVE = 3'd5,
      REG_AMOUNT      = 3'd6,
      REG_OUTPUT_MODE = 3'd7
   } reg_index_type;

   // curve kinds, codes four and up leave the port unused
   localparam logic [2:0] CURVE_LINEAR  = 3'd0;
   localparam logic [2:0] CURVE_CONCAVE = 3'd1;
   localparam logic [2:0] CURVE_CONVEX  = 3'd2;
   localparam logic [2:0] CURVE_SWITCH  = 3'd3;

   // output sign modes, mode three behaves as keep
   localparam logic [1:0] MODE_KEEP   = 2'd0;
   localparam logic [1:0] MODE_ABS    = 2'd1;
   localparam logic [1:0] MODE_NEGATE = 2'd2;

   // curve register layout, as written over the configuration port
   typedef struct packed {
      logic       reversed;
      logic       bipolar;
      logic [2:0] kind;
   } curve_cfg_type;

endpackage

// ===== design/mcm_lane.sv =====
// ----------------------------------------------------------------------------
// mcm_lane: one source port of the curve map
// clamp and normalise through a bit-per-stage divider, then shape the value
// with a bit-per-stage square root for the circular curves
// ----------------------------------------------------------------------------
module mcm_lane
   import mcm_pkg::*;
#(
   parameter int SOURCE_BITS = SOURCE_BITS_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   parameter int STAGES      = 2 * FRAC_BITS + 6
) (
   input  logic                         clock,
   input  logic [STAGES-1:0]            load,
   input  logic [SOURCE_BITS-1:0]       value,
   input  logic [SOURCE_BITS-1:0]       low,
   input  logic [SOURCE_BITS-1:0]       high,
   input  curve_cfg_type                cfg,
   output logic signed [FRAC_BITS+1:0]  y
);

   localparam int S  = SOURCE_BITS;
   localparam int F  = FRAC_BITS;
   localparam int XW = F + 2;
   localparam int AW = F + 3;
   localparam int RW = 2 * F + 1;
   localparam int XS = F + 2;
   localparam int YS = 2 * F + 5;

   localparam logic signed [XW-1:0] ONE_X  = XW'(1) << F;
   localparam logic signed [XW-1:0] HALF_X = XW'(1) << (F - 1);
   localparam logic signed [AW-1:0] ONE_A  = AW'(1) << F;

   // ---------------------------------------------------------------- clamp
   logic [S-1:0] smin, smax, sv, num, den;

   always_comb begin
      smin = (low < high) ? low : high;
      smax = (low < high) ? high : low;
      sv   = value;
      if (sv < smin) sv = smin;
      if (sv > smax) sv = smax;
      num  = (sv >= low) ? (sv - low) : (low - sv);
      den  = (high >= low) ? (high - low) : (low - high);
   end

   logic [S:0]   rem_ff  [0:F+1];
   logic [S-1:0] den_ff  [0:F+1];
   logic [F:0]   q_ff    [0:F+1];
   logic         zero_ff [0:F+1];

   always_ff @(posedge clock) begin
      if (load[0]) begin
         rem_ff[0]  <= {1'b0, num};
         den_ff[0]  <= den;
         q_ff[0]    <= '0;
         zero_ff[0] <= (low == high);
      end
   end

   // ------------------------------------------------------ divider stages
   for (genvar j = 0; j <= F; j++) begin : g_div
      logic [S:0] trial;
      logic       ge;
      logic [S:0] rem_in;

      always_comb begin
         trial  = (j == 0) ? rem_ff[j] : {rem_ff[j][S-1:0], 1'b0};
         ge     = (trial >= {1'b0, den_ff[j]});
         rem_in = ge ? (trial - {1'b0, den_ff[j]}) : trial;
      end

      always_ff @(posedge clock) begin
         if (load[j+1]) begin
            rem_ff[j+1]  <= rem_in;
            den_ff[j+1]  <= den_ff[j];
            q_ff[j+1]    <= {q_ff[j][F-1:0], ge};
            zero_ff[j+1] <= zero_ff[j];
         end
      end
   end

   // ------------------------------------- position and circle argument
   logic signed [XW-1:0] a_x, x_in;
   logic signed [AW-1:0] xa, arg;
   logic        [AW-1:0] mag;
   logic        [F:0]    t_in;

   always_comb begin
      a_x = signed'({1'b0, q_ff[F+1]});
      if (zero_ff[F+1])   x_in = '0;
      else if (cfg.bipolar) x_in = (a_x <<< 1) - ONE_X;
      else                x_in = a_x;
      xa  = {x_in[XW-1], x_in};
      arg = '0;
      case (cfg.kind)
         CURVE_CONCAVE: begin
            if (!cfg.bipolar)       arg = cfg.reversed ? (xa - ONE_A) : xa;
            else if (!cfg.reversed) arg = (xa < 0) ? (xa + ONE_A) : (xa - ONE_A);
            else                    arg = xa;
         end
         CURVE_CONVEX: begin
            if (!cfg.bipolar)       arg = cfg.reversed ? xa : (xa - ONE_A);
            else if (!cfg.reversed) arg = xa;
            else                    arg = (xa < 0) ? (xa + ONE_A) : (xa - ONE_A);
         end
         default: arg = '0;
      endcase
      mag  = (arg < 0) ? AW'(-arg) : AW'(arg);
      t_in = (mag > AW'(ONE_A)) ? (F+1)'(ONE_A) : mag[F:0];
   end

   logic signed [XW-1:0] x_ff [0:F+2];
   logic        [F:0]    t_ff;

   always_ff @(posedge clock) begin
      if (load[XS]) begin
         x_ff[0] <= x_in;
         t_ff    <= t_in;
      end
   end

   // ------------------------------------------------------------ radicand
   logic [RW-1:0] srem_ff [0:F+1];
   logic [F:0]    root_ff [0:F+1];
   logic [RW-1:0] tsq;

   assign tsq = RW'(t_ff) * RW'(t_ff);

   always_ff @(posedge clock) begin
      if (load[XS+1]) begin
         x_ff[1]    <= x_ff[0];
         srem_ff[0] <= (RW'(1) << (2 * F)) - tsq;
         root_ff[0] <= '0;
      end
   end

   // -------------------------------------------------- square root stages
   for (genvar i = 0; i <= F; i++) begin : g_sqrt
      localparam int B = F - i;
      logic [RW:0]   inc;
      logic          ge;
      logic [RW-1:0] srem_in;
      logic [F:0]    root_in;

      always_comb begin
         inc     = ((RW+1)'(root_ff[i]) << (B + 1)) + ((RW+1)'(1) << (2 * B));
         ge      = ({1'b0, srem_ff[i]} >= inc);
         srem_in = ge ? (srem_ff[i] - inc[RW-1:0]) : srem_ff[i];
         root_in = ge ? (root_ff[i] | ((F+1)'(1) << B)) : root_ff[i];
      end

      always_ff @(posedge clock) begin
         if (load[XS+2+i]) begin
            srem_ff[i+1] <= srem_in;
            root_ff[i+1] <= root_in;
            x_ff[i+2]    <= x_ff[i+1];
         end
      end
   end

   // ------------------------------------------------------- curve select
   logic signed [XW-1:0] cx, xl, y_in, y_ff;
   logic                 neg;

   always_comb begin
      cx  = signed'({1'b0, root_ff[F+1]});
      xl  = x_ff[F+2];
      neg = (xl < 0);
      case (cfg.kind)
         CURVE_LINEAR: begin
            if (!cfg.bipolar) y_in = cfg.reversed ? (ONE_X - xl) : xl;
            else              y_in = cfg.reversed ? -xl : xl;
         end
         CURVE_CONCAVE: begin
            if (!cfg.bipolar)       y_in = ONE_X - cx;
            else if (!cfg.reversed) y_in = neg ? -cx : cx;
            else                    y_in = neg ? (ONE_X - cx) : (cx - ONE_X);
         end
         CURVE_CONVEX: begin
            if (!cfg.bipolar)       y_in = cx;
            else if (!cfg.reversed) y_in = neg ? (cx - ONE_X) : (ONE_X - cx);
            else                    y_in = neg ? cx : -cx;
         end
         CURVE_SWITCH: begin
            if (!cfg.bipolar) begin
               if (!cfg.reversed) y_in = (xl < HALF_X) ? '0 : ONE_X;
               else               y_in = (xl < HALF_X) ? ONE_X : '0;
            end else begin
               if (!cfg.reversed) y_in = neg ? -ONE_X : ONE_X;
               else               y_in = neg ? ONE_X : -ONE_X;
            end
         end
         default: y_in = ONE_X;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load[YS]) y_ff <= y_in;
   end

   assign y = y_ff;

endmodule

// ===== design/mcm_merge.sv =====
// ----------------------------------------------------------------------------
// mcm_merge: combines both port values
// product of the ports, scale by amount, sign mode and saturation
// ----------------------------------------------------------------------------
module mcm_merge
   import mcm_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic [3:0]                  load,
   input  logic signed [FRAC_BITS+1:0] y0,
   input  logic signed [FRAC_BITS+1:0] y1,
   input  logic signed [15:0]          amount,
   input  logic [1:0]                  output_mode,
   output logic [15:0]                 result
);

   localparam int F  = FRAC_BITS;
   localparam int XW = F + 2;
   localparam int PW = 2 * XW;
   localparam int RW = XW + 16;

   // port product
   logic signed [PW-1:0] p_ff;

   always_ff @(posedge clock) begin
      if (load[0]) p_ff <= y0 * y1;
   end

   // drop fraction, toward zero
   logic signed [PW-1:0] p_adj;
   logic signed [XW-1:0] m_ff;

   assign p_adj = p_ff + ((p_ff < 0) ? PW'((1 << F) - 1) : PW'(0));

   always_ff @(posedge clock) begin
      if (load[1]) m_ff <= XW'(p_adj >>> F);
   end

   // scale by amount
   logic signed [RW-1:0] r_ff;

   always_ff @(posedge clock) begin
      if (load[2]) r_ff <= amount * m_ff;
   end

   // drop fraction, sign mode, saturate
   logic signed [RW-1:0] r_adj;
   logic signed [18:0]   r2, r3;
   logic [15:0]          result_in, result_ff;

   always_comb begin
      r_adj = r_ff + ((r_ff < 0) ? RW'((1 << F) - 1) : RW'(0));
      r2    = 19'(r_adj >>> F);
      case (output_mode)
         MODE_ABS:    r3 = (r2 < 0) ? -r2 : r2;
         MODE_NEGATE: r3 = -r2;
         default:     r3 = r2;
      endcase
      if (r3 > 19'sd32767)       result_in = 16'h7fff;
      else if (r3 < -19'sd32768) result_in = 16'h8000;
      else                       result_in = r3[15:0];
   end

   always_ff @(posedge clock) begin
      if (load[3]) result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

// ===== design/modulator_curve_map_unit.sv =====
// ----------------------------------------------------------------------------
// modulator_curve_map_unit: two-port modulator source mapping
// two curve lanes side by side and a merge stage, fully pipelined
// ----------------------------------------------------------------------------
// Takes one pair of source values per clock while not stalled and returns one
// modulation value per pair, in order. Each lane spends one stage per quotient
// bit in its normalising divider and one stage per root bit in its square root,
// and the merge adds four stages for the two multiplies and the final sign
// handling. Every stage holds when the next one is full, so a stalled result
// only stops intake once all stages are occupied. Registers must be written
// over the csr port only while no transaction is in flight; the block itself
// does not enforce this.
module modulator_curve_map_unit
   import mcm_pkg::*;
#(
   parameter int SOURCE_BITS = SOURCE_BITS_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   parameter int IN_W        = ((2 * SOURCE_BITS + 7) / 8) * 8
) (
   input  logic            clock,
   input  logic            reset,
   // input channel
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [IN_W-1:0] req_tdata,   // source_value0, source_value1
   // result channel
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [15:0]     rsp_tdata,   // mod_value
   // configuration port
   input  logic            csr_psel,
   input  logic            csr_penable,
   input  logic            csr_pwrite,
   input  logic [4:0]      csr_paddr,
   input  logic [31:0]     csr_pwdata,
   output logic [31:0]     csr_prdata,
   output logic            csr_pready
);

   localparam int S      = SOURCE_BITS;
   localparam int LANE_N = 2 * FRAC_BITS + 6;
   localparam int N      = LANE_N + 4;

   // ------------------------------------------------------------ registers
   logic [S-1:0]  p0_low_ff, p0_high_ff, p1_low_ff, p1_high_ff;
   curve_cfg_type p0_curve_ff, p1_curve_ff;
   logic [15:0]   amount_ff;
   logic [1:0]    mode_ff;
   logic          wr_en;
   reg_index_type idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign idx        = reg_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_low_ff   <= '0;
         p0_high_ff  <= '1;
         p1_low_ff   <= '0;
         p1_high_ff  <= '1;
         p0_curve_ff <= curve_cfg_type'(5'd4);
         p1_curve_ff <= curve_cfg_type'(5'd4);
         amount_ff   <= '0;
         mode_ff     <= MODE_KEEP;
      end else if (wr_en) begin
         unique case (idx)
            REG_PORT0_LOW:   p0_low_ff   <= csr_pwdata[S-1:0];
            REG_PORT0_HIGH:  p0_high_ff  <= csr_pwdata[S-1:0];
            REG_PORT1_LOW:   p1_low_ff   <= csr_pwdata[S-1:0];
            REG_PORT1_HIGH:  p1_high_ff  <= csr_pwdata[S-1:0];
            REG_PORT0_CURVE: p0_curve_ff <= curve_cfg_type'(csr_pwdata[4:0]);
            REG_PORT1_CURVE: p1_curve_ff <= curve_cfg_type'(csr_pwdata[4:0]);
            REG_AMOUNT:      amount_ff   <= csr_pwdata[15:0];
            REG_OUTPUT_MODE: mode_ff     <= csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (idx)
         REG_PORT0_LOW:   csr_prdata = 32'(p0_low_ff);
         REG_PORT0_HIGH:  csr_prdata = 32'(p0_high_ff);
         REG_PORT1_LOW:   csr_prdata = 32'(p1_low_ff);
         REG_PORT1_HIGH:  csr_prdata = 32'(p1_high_ff);
         REG_PORT0_CURVE: csr_prdata = 32'(p0_curve_ff);
         REG_PORT1_CURVE: csr_prdata = 32'(p1_curve_ff);
         REG_AMOUNT:      csr_prdata = 32'(amount_ff);
         REG_OUTPUT_MODE: csr_prdata = 32'(mode_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------- stage occupancy
   logic [N-1:0] valid_ff, valid_in, adv;

   always_comb begin
      adv[N-1] = ~valid_ff[N-1] | rsp_tready;
      for (int i = N - 2; i >= 0; i--) adv[i] = ~valid_ff[i] | adv[i+1];
      valid_in[0] = adv[0] ? req_tvalid : valid_ff[0];
      for (int i = 1; i < N; i++) valid_in[i] = adv[i] ? valid_ff[i-1] : valid_ff[i];
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else       valid_ff <= valid_in;
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = valid_ff[N-1];

   // ---------------------------------------------------------------- lanes
   logic signed [FRAC_BITS+1:0] y0, y1;

   mcm_lane #(.SOURCE_BITS(SOURCE_BITS), .FRAC_BITS(FRAC_BITS), .STAGES(LANE_N)) u_lane0 (
      .clock (clock),
      .load  (adv[LANE_N-1:0]),
      .value (req_tdata[S-1:0]),
      .low   (p0_low_ff),
      .high  (p0_high_ff),
      .cfg   (p0_curve_ff),
      .y     (y0)
   );

   mcm_lane #(.SOURCE_BITS(SOURCE_BITS), .FRAC_BITS(FRAC_BITS), .STAGES(LANE_N)) u_lane1 (
      .clock (clock),
      .load  (adv[LANE_N-1:0]),
      .value (req_tdata[2*S-1:S]),
      .low   (p1_low_ff),
      .high  (p1_high_ff),
      .cfg   (p1_curve_ff),
      .y     (y1)
   );

   // ---------------------------------------------------------------- merge
   mcm_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
      .clock       (clock),
      .load        (adv[N-1:LANE_N]),
      .y0          (y0),
      .y1          (y1),
      .amount      (signed'(amount_ff)),
      .output_mode (mode_ff),
      .result      (rsp_tdata)
   );

endmodule

// ===== design/mcm_checker.sv =====
// ----------------------------------------------------------------------------
// mcm_checker: port-level checks for the curve map unit
// result hold, transaction accounting and pipeline depth
// ----------------------------------------------------------------------------
module mcm_checker
   import mcm_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        csr_pready
);

   localparam int DEPTH = 2 * FRAC_BITS + 10;
   localparam int CW    = $clog2(DEPTH + 1);

   // transactions in flight
   logic [CW-1:0] cnt_ff;
   logic          acc_in, acc_out;

   assign acc_in  = req_tvalid & req_tready;
   assign acc_out = rsp_tvalid & rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else       cnt_ff <= cnt_ff + CW'(acc_in) - CW'(acc_out);
   end

   // a waiting result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // no result without an item in flight
   a_nothing_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> cnt_ff != '0)
      else $error("result without a pending transaction");

   // a full pipeline with a stalled output takes nothing
   a_full: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == CW'(DEPTH)) && !rsp_tready |-> !req_tready)
      else $error("input taken while pipeline full");

   // register port never waits
   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("csr_pready low");

endmodule

bind modulator_curve_map_unit mcm_checker #(.FRAC_BITS(FRAC_BITS)) u_mcm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);
